/* sv/bpa_pkg.sv */
// ----------------------------------------------------------------------------
// Brightness pattern animator package
// Field widths, operation codes, default pattern tables and the control
// structs shared by the sequencer and the serial divider.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int NUM_STYLES      = 64;
    localparam int MAX_PATTERN_LEN = 64;
    localparam int FRACTION_BITS   = 16;

    // Fixed field widths of the streaming items.
    localparam int OP_W        = 2;
    localparam int STYLE_FLD_W = 6;
    localparam int POS_FLD_W   = 6;
    localparam int LETTER_W    = 5;
    localparam int LENGTH_W    = 7;
    localparam int DELTA_W     = 22;
    localparam int BASE_W      = 32;
    localparam int MULT_W      = 18;
    localparam int INTEN_W     = 34;
    localparam int FC_W        = 32;
    localparam int MULT_FRAC   = 16;

    localparam int IN_FIELDS_W  = STYLE_FLD_W + POS_FLD_W + LETTER_W + LENGTH_W
                                  + DELTA_W + BASE_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + MULT_W + INTEN_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Storage geometry.
    localparam int STYLE_W = $clog2(NUM_STYLES);
    localparam int POS_W   = $clog2(MAX_PATTERN_LEN);
    localparam int ADDR_W  = STYLE_W + POS_W;
    localparam int LEN_W   = $clog2(MAX_PATTERN_LEN + 1);

    // Interpolation and scaling widths.
    localparam int NUM_W   = FRACTION_BITS + LETTER_W;
    localparam int X_W     = NUM_W + MULT_FRAC + 1;
    localparam int Q_W     = X_W - (FRACTION_BITS + 2);
    localparam int SUM_W   = ((FRACTION_BITS > DELTA_W) ? FRACTION_BITS : DELTA_W) + 1;
    localparam int PROD_W  = BASE_W + MULT_W;

    // Serial divider geometry.
    localparam int DIV_W  = FC_W;
    localparam int STEP_W = $clog2(DIV_W + 1);

    localparam logic [LETTER_W-1:0] NORMAL_LETTER = LETTER_W'(12);
    localparam logic [LETTER_W-1:0] TOP_LETTER    = LETTER_W'(25);
    localparam logic [MULT_W-1:0]   UNITY_MULT    = MULT_W'(1) << MULT_FRAC;

    // Division by three as a multiply by the rounded-up reciprocal; exact
    // for every dividend below 2^Q_W.
    localparam int             RECIP_SHIFT = Q_W + 1;
    localparam logic [Q_W-1:0] RECIP_THREE = Q_W'(((1 << RECIP_SHIFT) + 2) / 3);

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_LETTER = 2'd0,
        OP_SET_LENGTH   = 2'd1,
        OP_ADVANCE      = 2'd2,
        OP_EVALUATE     = 2'd3
    } op_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Default patterns, first letter in the highest used byte position of the
    // string literal (string literals are right-justified).
    localparam int DEFAULT_COUNT = 12;
    localparam int DEF_IDX_W     = $clog2(DEFAULT_COUNT);
    localparam int TXT_W         = 8 * MAX_PATTERN_LEN;

    localparam logic [TXT_W-1:0] DEF_TXT [DEFAULT_COUNT] = '{
        "m",
        "mmnmmommommnonmmonqnmmo",
        "abcdefghijklmnopqrstuvwxyzyxwvutsrqponmlkjihgfedcba",
        "mmmmmaaaaammmmmaaaaaabcdefgabcdefg",
        "mamamamamama",
        "jklmnopqrstuvwxyzyxwvutsrqponmlkj",
        "nmonqnmomnmomomno",
        "mmmaaaabcdefgmmmmaaaammmaamm",
        "mmmaaaammmaaammmabcdefaaaammmmabcdefmmmaaaa",
        "aaaaaaaazzzzzzzz",
        "mmamammmmammamamaaamammma",
        "abcdefghijklmnopqrrqponmlkjihgfedcba"
    };

    function automatic logic [LEN_W-1:0] txt_len(input logic [TXT_W-1:0] t);
        int n;
        n = 0;
        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
            if (t[8*i +: 8] != 8'h00) begin
                n = i + 1;
            end
        end
        if (n == 0) begin
            n = 1;
        end
        return LEN_W'(n);
    endfunction

    localparam logic [LEN_W-1:0] DEF_LEN [DEFAULT_COUNT] = '{
        txt_len(DEF_TXT[0]),  txt_len(DEF_TXT[1]),  txt_len(DEF_TXT[2]),
        txt_len(DEF_TXT[3]),  txt_len(DEF_TXT[4]),  txt_len(DEF_TXT[5]),
        txt_len(DEF_TXT[6]),  txt_len(DEF_TXT[7]),  txt_len(DEF_TXT[8]),
        txt_len(DEF_TXT[9]),  txt_len(DEF_TXT[10]), txt_len(DEF_TXT[11])
    };

    // Letter held at reset by one table entry.
    function automatic logic [LETTER_W-1:0] default_letter(
        input logic [STYLE_W-1:0] s,
        input logic [POS_W-1:0]   p
    );
        logic [DEF_IDX_W-1:0] idx;
        logic [7:0]           ch;
        int                   n;
        default_letter = NORMAL_LETTER;
        if (int'(s) < DEFAULT_COUNT) begin
            idx = DEF_IDX_W'(s);
            n   = int'(DEF_LEN[idx]);
            if (int'(p) < n) begin
                ch = DEF_TXT[idx][8*(n - 1 - int'(p)) +: 8];
                default_letter = LETTER_W'(ch - 8'h61);
            end
        end
    endfunction

    function automatic logic [LEN_W-1:0] default_length(input logic [STYLE_W-1:0] s);
        logic [LEN_W-1:0] len;
        len = LEN_W'(1);
        if (int'(s) < DEFAULT_COUNT) begin
            len = DEF_LEN[DEF_IDX_W'(s)];
        end
        return len;
    endfunction

endpackage

/* sv/bpa_ram.sv */
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sv/bpa_divider.sv */
// ----------------------------------------------------------------------------
// Serial restoring divider
// One compare-and-subtract step per cycle; produces the remainder of the
// frame count by the pattern length for the keyframe index.
// ----------------------------------------------------------------------------
module bpa_divider (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  bpa_pkg::div_ctrl_t         ctrl,
    input  logic [bpa_pkg::DIV_W-1:0]  dividend,
    input  logic [bpa_pkg::LEN_W-1:0]  divisor,
    output bpa_pkg::div_stat_t         stat,
    output logic [bpa_pkg::LEN_W-1:0]  remainder
);
    import bpa_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DIV_W-1:0]  shift_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic [LEN_W-1:0]  dsr_reg;

    logic [LEN_W:0] trial;
    logic [LEN_W:0] diff;
    logic           take;

    // The partial remainder stays below the divisor, so the shifted trial
    // value always fits one bit more than the divisor.
    assign trial = {rem_reg, shift_reg[DIV_W-1]};
    assign take  = (trial >= {1'b0, dsr_reg});
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctrl.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            dsr_reg   <= divisor;
        end else if (busy_reg) begin
            shift_reg <= {shift_reg[DIV_W-2:0], 1'b0};
            rem_reg   <= take ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

endmodule

/* sv/brightness_pattern_animator.sv */
// ----------------------------------------------------------------------------
// Brightness pattern animator
// Keeps 64 letter patterns and a frame clock; each input transfer is one
// operation (write letter, set length, advance clock, evaluate light) and
// yields exactly one result transfer: status, multiplier and intensity.
// The input s_ channel is ready only while the sequencer is idle. Write,
// length and clock operations go straight to the done state; a new item is
// taken only after the result leaves it. An evaluation runs a 32-step serial
// modulo for the keyframe index, two pattern memory reads, the interpolation
// multiply, a reciprocal multiply for the divide by three of the rounding
// and the intensity multiply; the next evaluation is taken only after its
// result leaves the done state.
// Style 0 skips to the intensity multiply.
// A finished result waits in the m_ output register; the next item is taken
// while it waits, and the sequencer holds its result until the register is
// free when m_tready stays low.
// After reset the pattern memory is loaded with the default patterns in a
// pass over all 4096 letters, one letter per cycle; s_tready stays low meanwhile.
// ----------------------------------------------------------------------------
module brightness_pattern_animator (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // style, position, letter, length, delta_time, base_intensity, zero pad
    input  logic [bpa_pkg::IN_TDATA_W-1:0]   s_tdata,
    // operation
    input  logic [bpa_pkg::OP_W-1:0]         s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status, multiplier, intensity, zero pad
    output logic [bpa_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import bpa_pkg::*;

    typedef enum logic [9:0] {
        ST_CLEAR  = 10'b0000000001,
        ST_IDLE   = 10'b0000000010,
        ST_LEN    = 10'b0000000100,
        ST_MOD    = 10'b0000001000,
        ST_RD0    = 10'b0000010000,
        ST_RD1    = 10'b0000100000,
        ST_INTERP = 10'b0001000000,
        ST_QDIV   = 10'b0010000000,
        ST_SCALE  = 10'b0100000000,
        ST_DONE   = 10'b1000000000
    } state_t;

    localparam int STYLE_LSB  = 0;
    localparam int POS_LSB    = STYLE_LSB + STYLE_FLD_W;
    localparam int LETTER_LSB = POS_LSB + POS_FLD_W;
    localparam int LENGTH_LSB = LETTER_LSB + LETTER_W;
    localparam int DELTA_LSB  = LENGTH_LSB + LENGTH_W;
    localparam int BASE_LSB   = DELTA_LSB + DELTA_W;

    state_t state_reg, state_next;

    // Input fields.
    op_t                  in_op;
    logic [STYLE_FLD_W-1:0] in_style;
    logic [POS_FLD_W-1:0] in_position;
    logic [LETTER_W-1:0]  in_letter;
    logic [LENGTH_W-1:0]  in_length;
    logic [DELTA_W-1:0]   in_delta;
    logic [BASE_W-1:0]    in_base;
    logic                 accept;

    assign in_op       = op_t'(s_tuser);
    assign in_style    = s_tdata[STYLE_LSB  +: STYLE_FLD_W];
    assign in_position = s_tdata[POS_LSB    +: POS_FLD_W];
    assign in_letter   = s_tdata[LETTER_LSB +: LETTER_W];
    assign in_length   = s_tdata[LENGTH_LSB +: LENGTH_W];
    assign in_delta    = s_tdata[DELTA_LSB  +: DELTA_W];
    assign in_base     = s_tdata[BASE_LSB   +: BASE_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Control state.
    logic [ADDR_W-1:0]        clr_idx_reg;
    logic [FC_W-1:0]          frame_count_reg;
    logic [FRACTION_BITS-1:0] frame_frac_reg;
    logic                     out_valid_reg;

    // Working registers.
    logic [STYLE_W-1:0]  style_reg;
    logic [BASE_W-1:0]   base_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [POS_W-1:0]    i1_reg;
    logic [LETTER_W-1:0] v0_reg;
    logic [LETTER_W-1:0] v1_reg;
    logic [NUM_W-1:0]    num_reg;
    logic                res_status_reg;
    logic [MULT_W-1:0]   res_mult_reg;
    logic [INTEN_W-1:0]  res_inten_reg;
    logic                out_status_reg;
    logic [MULT_W-1:0]   out_mult_reg;
    logic [INTEN_W-1:0]  out_inten_reg;

    // Memory ports.
    logic                let_wr_en;
    logic [ADDR_W-1:0]   let_wr_addr;
    logic [LETTER_W-1:0] let_wr_data;
    logic                let_rd_en;
    logic [ADDR_W-1:0]   let_rd_addr;
    logic [LETTER_W-1:0] let_rd_data;
    logic                len_wr_en;
    logic [STYLE_W-1:0]  len_wr_addr;
    logic [LEN_W-1:0]    len_wr_data;
    logic [LEN_W-1:0]    len_rd_data;

    // Divider.
    div_ctrl_t        div_ctrl;
    div_stat_t        div_stat;
    logic [DIV_W-1:0] div_dividend;
    logic [LEN_W-1:0] div_divisor;
    logic [LEN_W-1:0] div_rem;

    // Datapath helpers.
    logic                 style_bad;
    logic                 pos_bad;
    logic                 in_status;
    logic                 out_free;
    logic [SUM_W-1:0]     frame_sum;
    logic [LEN_W-1:0]     len_fix;
    logic [POS_W-1:0]     idx0;
    logic [LEN_W-1:0]     idx0_inc;
    logic [POS_W-1:0]     idx1;
    logic [FRACTION_BITS:0] one_minus;
    logic [NUM_W:0]       part0;
    logic [NUM_W:0]       part1;
    logic [NUM_W:0]       num_sum;
    logic [X_W-1:0]       round_x;
    logic [Q_W-1:0]       round_q;
    logic [2*Q_W-1:0]     recip_prod;
    logic [PROD_W-1:0]    prod;

    assign style_bad = (int'(in_style) >= NUM_STYLES);
    assign pos_bad   = (int'(in_position) >= MAX_PATTERN_LEN);
    assign out_free  = !out_valid_reg || m_tready;

    always_comb begin
        unique case (in_op)
            OP_WRITE_LETTER: in_status = style_bad || pos_bad;
            OP_SET_LENGTH:   in_status = style_bad || (in_length == '0);
            OP_ADVANCE:      in_status = 1'b0;
            OP_EVALUATE:     in_status = 1'b0;
            default:         in_status = 1'b0;
        endcase
    end

    assign frame_sum = SUM_W'(frame_frac_reg) + SUM_W'(in_delta);

    // A stored length outside 1..MAX_PATTERN_LEN is treated as one.
    assign len_fix = ((len_rd_data == '0) || (int'(len_rd_data) > MAX_PATTERN_LEN))
                     ? LEN_W'(1) : len_rd_data;

    assign idx0     = div_rem[POS_W-1:0];
    assign idx0_inc = LEN_W'(idx0) + LEN_W'(1);
    assign idx1     = (idx0_inc == len_reg) ? '0 : idx0_inc[POS_W-1:0];

    assign one_minus = (FRACTION_BITS+1)'(1) << FRACTION_BITS;
    assign part0   = (NUM_W+1)'(v0_reg) * (NUM_W+1)'(one_minus - (FRACTION_BITS+1)'(frame_frac_reg));
    assign part1   = (NUM_W+1)'(v1_reg) * (NUM_W+1)'(frame_frac_reg);
    assign num_sum = part0 + part1;

    // Rounded num / 12 in multiplier units: the power-of-two part of the
    // divisor is a shift, the factor three is a reciprocal multiply.
    assign round_x    = (X_W'(num_reg) << MULT_FRAC) + (X_W'(6) << FRACTION_BITS);
    assign round_q    = Q_W'(round_x >> (FRACTION_BITS + 2));
    assign recip_prod = (2*Q_W)'(round_q) * (2*Q_W)'(RECIP_THREE);

    assign prod = PROD_W'(base_reg) * PROD_W'(res_mult_reg);

    // Letter memory ports.
    always_comb begin
        let_wr_en   = 1'b0;
        let_wr_addr = clr_idx_reg;
        let_wr_data = default_letter(clr_idx_reg[ADDR_W-1:POS_W], clr_idx_reg[POS_W-1:0]);
        if (state_reg == ST_CLEAR) begin
            let_wr_en = 1'b1;
        end else if (accept && (in_op == OP_WRITE_LETTER) && !style_bad && !pos_bad) begin
            let_wr_en   = 1'b1;
            let_wr_addr = {STYLE_W'(in_style), POS_W'(in_position)};
            let_wr_data = (in_letter > TOP_LETTER) ? TOP_LETTER : in_letter;
        end
    end

    assign let_rd_en   = ((state_reg == ST_MOD) && div_stat.done) || (state_reg == ST_RD0);
    assign let_rd_addr = (state_reg == ST_RD0) ? {style_reg, i1_reg} : {style_reg, idx0};

    // Length memory ports; defaults go in while the clear pass is at the
    // first letter of each style.
    always_comb begin
        len_wr_en   = 1'b0;
        len_wr_addr = clr_idx_reg[ADDR_W-1:POS_W];
        len_wr_data = default_length(clr_idx_reg[ADDR_W-1:POS_W]);
        if (state_reg == ST_CLEAR) begin
            len_wr_en = (clr_idx_reg[POS_W-1:0] == '0);
        end else if (accept && (in_op == OP_SET_LENGTH) && !in_status) begin
            len_wr_en   = 1'b1;
            len_wr_addr = STYLE_W'(in_style);
            len_wr_data = (int'(in_length) > MAX_PATTERN_LEN)
                          ? LEN_W'(MAX_PATTERN_LEN) : LEN_W'(in_length);
        end
    end

    bpa_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (LETTER_W)
    ) u_letter_ram (
        .clk     (aclk),
        .wr_en   (let_wr_en),
        .wr_addr (let_wr_addr),
        .wr_data (let_wr_data),
        .rd_en   (let_rd_en),
        .rd_addr (let_rd_addr),
        .rd_data (let_rd_data)
    );

    bpa_ram #(
        .ADDR_W (STYLE_W),
        .DATA_W (LEN_W)
    ) u_length_ram (
        .clk     (aclk),
        .wr_en   (len_wr_en),
        .wr_addr (len_wr_addr),
        .wr_data (len_wr_data),
        .rd_en   (accept),
        .rd_addr (STYLE_W'(in_style)),
        .rd_data (len_rd_data)
    );

    // Divider: keyframe modulo of the frame count by the pattern length.
    always_comb begin
        div_ctrl.start = (state_reg == ST_LEN);
        div_ctrl.steps = STEP_W'(DIV_W);
        div_dividend   = frame_count_reg;
        div_divisor    = len_fix;
    end

    bpa_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (div_ctrl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .remainder (div_rem)
    );

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_idx_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (in_op != OP_EVALUATE) begin
                        state_next = ST_DONE;
                    end else if ((in_style == '0) || style_bad) begin
                        state_next = ST_SCALE;
                    end else begin
                        state_next = ST_LEN;
                    end
                end
            end
            ST_LEN:    state_next = ST_MOD;
            ST_MOD: begin
                if (div_stat.done) begin
                    state_next = ST_RD0;
                end
            end
            ST_RD0:    state_next = ST_RD1;
            ST_RD1:    state_next = ST_INTERP;
            ST_INTERP: state_next = ST_QDIV;
            ST_QDIV:   state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_idx_reg     <= '0;
            frame_count_reg <= '0;
            frame_frac_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + ADDR_W'(1);
            end
            if (accept && (in_op == OP_ADVANCE)) begin
                frame_count_reg <= frame_count_reg + FC_W'(frame_sum >> FRACTION_BITS);
                frame_frac_reg  <= frame_sum[FRACTION_BITS-1:0];
            end
            if ((state_reg == ST_DONE) && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            style_reg      <= STYLE_W'(in_style);
            base_reg       <= in_base;
            res_status_reg <= in_status;
            res_mult_reg   <= (in_op == OP_EVALUATE) ? UNITY_MULT : '0;
            res_inten_reg  <= '0;
        end
        if (state_reg == ST_LEN) begin
            len_reg <= len_fix;
        end
        if ((state_reg == ST_MOD) && div_stat.done) begin
            i1_reg <= idx1;
        end
        if (state_reg == ST_RD0) begin
            v0_reg <= let_rd_data;
        end
        if (state_reg == ST_RD1) begin
            v1_reg <= let_rd_data;
        end
        if (state_reg == ST_INTERP) begin
            num_reg <= num_sum[NUM_W-1:0];
        end
        if (state_reg == ST_QDIV) begin
            res_mult_reg <= MULT_W'(recip_prod >> RECIP_SHIFT);
        end
        // A Q16.16 base times a Q2.16 multiplier, shifted back, always fits
        // the 34-bit intensity, so the saturation bound is never reached.
        if (state_reg == ST_SCALE) begin
            res_inten_reg <= prod[PROD_W-1:MULT_FRAC];
        end
        if ((state_reg == ST_DONE) && out_free) begin
            out_status_reg <= res_status_reg;
            out_mult_reg   <= res_mult_reg;
            out_inten_reg  <= res_inten_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), out_inten_reg, out_mult_reg,
                       out_status_reg};

`ifndef SYNTHESIS
    // The sequencer must not take a new transfer while the divider is working.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> !s_tready)
        else $error("input accepted while divider busy");

    // Unanimated evaluations go straight to the intensity multiply.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (in_op == OP_EVALUATE) && (in_style == '0)) |=> (state_reg == ST_SCALE))
        else $error("style 0 evaluation did not bypass interpolation");

    // A divider completion is only ever seen by the state waiting for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_MOD))
        else $error("divider completed outside its wait state");
`endif

endmodule
